### design/cdq_pkg.sv
// Shared types and codes of the circular deque engine.
// Depends on nothing; imported by circular_deque_engine, cdq_result_check and the testbench.
package cdq_pkg;

    localparam int WORD_W   = 32;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    typedef logic [OP_W-1:0]     t_op;
    typedef logic [STATUS_W-1:0] t_status;
    typedef logic signed [WORD_W-1:0] t_word;

    // operation codes
    localparam t_op OP_PUSH_FRONT = 3'd0;
    localparam t_op OP_PUSH_REAR  = 3'd1;
    localparam t_op OP_POP_FRONT  = 3'd2;
    localparam t_op OP_POP_REAR   = 3'd3;
    localparam t_op OP_DUMP       = 3'd4;

    // result status codes
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_OVERFLOW  = 2'd1;
    localparam t_status ST_UNDERFLOW = 2'd2;

endpackage

### design/circular_deque_engine.sv
// Double-ended queue held in a ring memory with wrapping head and tail.
// Depends on cdq_pkg (codes and word type).
//
//  channel | direction | handshake                  | word
//  --------+-----------+----------------------------+----------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_op, i_value
//  out     | output    | o_out_valid / i_out_ready  | o_status, o_data, o_last
//
// Timing: a push, an overflow or an underflow leaves the block idle, so the
// next operation may follow at once while the output is free; a pop passes
// through S_POP for the registered read of the ring memory; a dump lists the
// stored words from S_DUMP, one memory read per listed word.
// Reset (i_rst_n low at a clock edge) empties the deque; the ring memory is
// not cleared, only occupied entries are ever read.
// A stalled output holds the result register; the input is taken again once
// the pending result has a place to go.
module circular_deque_engine #(
    parameter int DEPTH = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // operation channel
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  cdq_pkg::t_op               i_op,
    input  cdq_pkg::t_word             i_value,
    // result channel
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output cdq_pkg::t_status           o_status,
    output cdq_pkg::t_word             o_data,
    output logic                       o_last
);
    import cdq_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,     // take the next operation
        S_RESP,     // hold a fixed result until the output frees
        S_POP,      // read data returns, pass it out
        S_DUMP      // list stored words, one per cycle while the output is free
    } t_state;

    // wrap an index forward by one
    function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
        return (i == AW'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    // wrap an index backward by one
    function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
        return (i == '0) ? AW'(DEPTH - 1) : i - 1'b1;
    endfunction

    // ring memory: one write port, one registered read port
    t_word           ring_mem [DEPTH];
    t_word           r_rd_data;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;

    t_state          r_state,  n_state;
    logic [AW-1:0]   r_head,   n_head;
    logic [AW-1:0]   r_tail,   n_tail;
    logic [CW-1:0]   r_count,  n_count;
    logic [AW-1:0]   r_pos,    n_pos;
    logic [CW-1:0]   r_left,   n_left;
    t_status         r_pend,   n_pend;
    logic            r_out_valid, n_out_valid;
    t_status         r_status, n_status;
    t_word           r_data,   n_data;
    logic            r_last,   n_last;

    logic            in_acc;
    logic            out_free;
    logic            is_full;
    logic            is_empty;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;
    assign is_full    = (r_count == CW'(DEPTH));
    assign is_empty   = (r_count == '0);

    // A pop reads only in a later cycle than any earlier push wrote, and a
    // dump never writes, so a read and a write of one entry never meet in
    // the same cycle: no forwarding path is needed.
    always_comb begin
        logic    fixed_resp;
        t_status resp_st;

        fixed_resp  = 1'b0;
        resp_st     = ST_OK;
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_pos       = r_pos;
        n_left      = r_left;
        n_pend      = r_pend;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_data      = r_data;
        n_last      = r_last;
        wr_en       = 1'b0;
        wr_addr     = r_tail;
        rd_en       = 1'b0;
        rd_addr     = r_head;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_op)
                        OP_PUSH_FRONT, OP_PUSH_REAR: begin
                            fixed_resp = 1'b1;
                            if (is_full) begin
                                resp_st = ST_OVERFLOW;
                            end else begin
                                wr_en   = 1'b1;
                                n_count = r_count + 1'b1;
                                if (i_op == OP_PUSH_FRONT) begin
                                    wr_addr = idx_prev(r_head);
                                    n_head  = idx_prev(r_head);
                                end else begin
                                    wr_addr = r_tail;
                                    n_tail  = idx_next(r_tail);
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_REAR: begin
                            if (is_empty) begin
                                fixed_resp = 1'b1;
                                resp_st    = ST_UNDERFLOW;
                            end else begin
                                rd_en   = 1'b1;
                                n_count = r_count - 1'b1;
                                n_state = S_POP;
                                if (i_op == OP_POP_FRONT) begin
                                    rd_addr = r_head;
                                    n_head  = idx_next(r_head);
                                end else begin
                                    rd_addr = idx_prev(r_tail);
                                    n_tail  = idx_prev(r_tail);
                                end
                            end
                        end
                        OP_DUMP: begin
                            if (is_empty) begin
                                fixed_resp = 1'b1;
                                resp_st    = ST_UNDERFLOW;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = r_head;
                                n_pos   = idx_next(r_head);
                                n_left  = r_count;
                                n_state = S_DUMP;
                            end
                        end
                        default: begin
                            // unused codes: drop the word
                        end
                    endcase

                    if (fixed_resp) begin
                        if (out_free) begin
                            n_out_valid = 1'b1;
                            n_status    = resp_st;
                            n_data      = '0;
                            n_last      = 1'b1;
                        end else begin
                            n_pend  = resp_st;
                            n_state = S_RESP;
                        end
                    end
                end
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = r_pend;
                    n_data      = '0;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_POP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_data      = r_rd_data;
                    n_last      = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_OK;
                    n_data      = r_rd_data;
                    n_last      = (r_left == CW'(1));
                    if (r_left == CW'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        // advance to the next stored word
                        rd_en   = 1'b1;
                        rd_addr = r_pos;
                        n_pos   = idx_next(r_pos);
                        n_left  = r_left - 1'b1;
                    end
                end
            end
        endcase
    end

    // state, indices and the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_pos    <= n_pos;
        r_left   <= n_left;
        r_pend   <= n_pend;
        r_status <= n_status;
        r_data   <= n_data;
        r_last   <= n_last;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            ring_mem[wr_addr] <= i_value;
        end
    end

    // read data holds while no read is issued, so a stalled pop keeps it
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= ring_mem[rd_addr];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_data      = r_data;
    assign o_last      = r_last;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("element count beyond ring depth");

    a_ends_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0 || r_count == CW'(DEPTH)) |-> r_head == r_tail)
        else $error("head and tail disagree with an empty or full ring");

    a_push_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !is_full && (i_op == OP_PUSH_FRONT || i_op == OP_PUSH_REAR))
        |=> r_count == $past(r_count) + 1'b1)
        else $error("accepted push did not grow the count");

    a_pop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && !is_empty && (i_op == OP_POP_FRONT || i_op == OP_POP_REAR))
        |=> r_count == $past(r_count) - 1'b1)
        else $error("accepted pop did not shrink the count");

    a_dump_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DUMP |-> (r_left != '0 && r_left <= r_count))
        else $error("dump word counter out of range");
`endif

endmodule

### verif/cdq_result_check.sv
// Result checker for circular_deque_engine: mirrors the deque, predicts every
// result word from the accepted operation words and compares field by field.
// Depends on cdq_pkg for the word type, operation codes and status codes.
module cdq_result_check #(
    parameter int DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  cdq_pkg::t_op     i_op,
    input  cdq_pkg::t_word   i_value,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  cdq_pkg::t_status i_status,
    input  cdq_pkg::t_word   i_data,
    input  logic             i_last,
    output int               o_errors,
    output int               o_pending
);
    import cdq_pkg::*;

    typedef struct packed {
        t_status status;
        t_word   data;
        logic    last;
    } t_result;

    t_result expected_results[$];

    // mirror of the deque
    t_word ring_copy [DEPTH];
    int    front_idx;
    int    rear_idx;
    int    stored;
    int    mismatch_count = 0;
    int    pending_words  = 0;

    assign o_errors  = mismatch_count;
    assign o_pending = pending_words;

    function automatic int wrap_next(input int idx);
        return (idx + 1 == DEPTH) ? 0 : idx + 1;
    endfunction

    function automatic int wrap_prev(input int idx);
        return (idx == 0) ? DEPTH - 1 : idx - 1;
    endfunction

    function automatic t_result make_result(input t_status st, input t_word d, input logic l);
        t_result r;
        r.status = st;
        r.data   = d;
        r.last   = l;
        return r;
    endfunction

    // Apply one operation to the mirror and queue the result words it causes.
    task automatic apply_deque_op(input t_op op, input t_word value);
        int   pos;
        int   n;
        t_word popped;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_REAR: begin
                if (stored == DEPTH) begin
                    expected_results.push_back(make_result(ST_OVERFLOW, '0, 1'b1));
                end else begin
                    if (op == OP_PUSH_FRONT) begin
                        front_idx = wrap_prev(front_idx);
                        ring_copy[front_idx] = value;
                    end else begin
                        ring_copy[rear_idx] = value;
                        rear_idx = wrap_next(rear_idx);
                    end
                    stored++;
                    expected_results.push_back(make_result(ST_OK, '0, 1'b1));
                end
            end
            OP_POP_FRONT, OP_POP_REAR: begin
                if (stored == 0) begin
                    expected_results.push_back(make_result(ST_UNDERFLOW, '0, 1'b1));
                end else begin
                    if (op == OP_POP_FRONT) begin
                        popped    = ring_copy[front_idx];
                        front_idx = wrap_next(front_idx);
                    end else begin
                        rear_idx = wrap_prev(rear_idx);
                        popped   = ring_copy[rear_idx];
                    end
                    stored--;
                    expected_results.push_back(make_result(ST_OK, popped, 1'b1));
                end
            end
            OP_DUMP: begin
                if (stored == 0) begin
                    expected_results.push_back(make_result(ST_UNDERFLOW, '0, 1'b1));
                end else begin
                    pos = front_idx;
                    for (n = 0; n < stored; n++) begin
                        expected_results.push_back(
                            make_result(ST_OK, ring_copy[pos], n + 1 == stored));
                        pos = wrap_next(pos);
                    end
                end
            end
            default: ; // spare codes: drop, no result
        endcase
    endtask

    task automatic note_mismatch(input string what, input t_result want, input t_result got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("cdq_result_check: %s: want %0d/%h/%0b, got %0d/%h/%0b",
                     what, want.status, want.data, want.last,
                     got.status, got.data, got.last);
    endtask

    always @(posedge i_clk) begin : watch
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            front_idx = 0;
            rear_idx  = 0;
            stored    = 0;
            expected_results.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                apply_deque_op(i_op, i_value);
            if (i_out_valid && i_out_ready) begin
                got.status = i_status;
                got.data   = i_data;
                got.last   = i_last;
                if (expected_results.size() == 0) begin
                    note_mismatch("result with none expected", '0, got);
                end else begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status || got.data !== want.data
                            || got.last !== want.last)
                        note_mismatch("result differs", want, got);
                end
            end
        end
        pending_words = expected_results.size();
    end

endmodule

### verif/tb_circular_deque_engine.sv
// Testbench top for circular_deque_engine: drives operation words, paces the
// result channel and prints the verdict. Depends on cdq_pkg, the block and
// cdq_result_check, which does all prediction and comparison.
module tb_circular_deque_engine;
    import cdq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_WORDS = 350;
    localparam int CYCLE_LIMIT  = 400000;
    // a full dump lists DEPTH words; leave room for a stray word
    localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
    localparam int HOLD_CYCLES  = 90;

    // codes the block must ignore
    localparam t_op OP_SPARE_LO = 3'd5;
    localparam t_op OP_SPARE_HI = 3'd7;

    logic     clk        = 1'b0;
    logic     rst_n      = 1'b0;
    logic     in_valid   = 1'b0;
    logic     in_ready;
    t_op      in_op      = OP_DUMP;
    t_word    in_value   = '0;
    logic     out_valid;
    logic     out_ready  = 1'b0;
    t_status  out_status;
    t_word    out_data;
    logic     out_last;

    int       mismatches;
    int       pending_words;
    int       words_sent     = 0;
    int       cycle_count    = 0;
    int       rx_hold_cycles = 0;
    bit       tx_idle        = 1'b1;
    bit       rx_idle        = 1'b1;

    circular_deque_engine #(.DEPTH(DEPTH)) i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_op        (in_op),
        .i_value     (in_value),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_status    (out_status),
        .o_data      (out_data),
        .o_last      (out_last)
    );

    cdq_result_check #(.DEPTH(DEPTH)) i_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_op        (in_op),
        .i_value     (in_value),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_status    (out_status),
        .i_data      (out_data),
        .i_last      (out_last),
        .o_errors    (mismatches),
        .o_pending   (pending_words)
    );

    always #6 clk = ~clk;

    // Watchdog: end the run if the block hangs or loses a word.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("tb_circular_deque_engine: errors");
            $finish;
        end
    end

    // Bias values towards the extremes of the signed word range.
    function automatic t_word pick_word();
        case ($urandom_range(0, 7))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_op random_push();
        return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
    endfunction

    // Offer one operation word, after a random gap while tx_idle is set, and hold it until taken.
    // Valid stays high on return so back-to-back words need no dip.
    task automatic send_op(input t_op op, input t_word value);
        int gap;
        gap = tx_idle ? $urandom_range(0, 7) : 0;
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_op    <= op;
        in_value <= value;
        do @(posedge clk); while (!in_ready);
        if (op <= OP_DUMP)
            words_sent++;
    endtask

    // Drop valid and hold off until every predicted result word has left.
    task automatic wait_for_drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_words != 0) @(negedge clk);
    endtask

    // Result side: draw a stall per word while rx_idle is set, or take a long hold-off on request.
    initial begin : result_sink
        int gap;
        forever begin
            gap = rx_idle ? $urandom_range(0, 7) : 0;
            if (rx_hold_cycles > 0) begin
                gap            = rx_hold_cycles;
                rx_hold_cycles = 0;
            end
            @(negedge clk);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
        end
    end

    initial begin : stimulus
        int  k;
        int  run_len;
        int  random_end;
        int  hold_at;
        bit  hold_done;

        hold_done = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Empty deque: every removal and the dump must underflow.
        send_op(OP_POP_FRONT, pick_word());
        send_op(OP_POP_REAR, 32'h5A5A_A5A5);
        send_op(OP_DUMP, '1);

        // Extremes of the word at both ends; head index wraps below zero.
        send_op(OP_PUSH_REAR, 32'h7FFF_FFFF);
        send_op(OP_PUSH_FRONT, 32'h8000_0000);
        send_op(OP_PUSH_REAR, '0);
        send_op(OP_PUSH_FRONT, '1);
        send_op(OP_POP_FRONT, '0);
        send_op(OP_POP_REAR, '1);

        // Spare codes: no result, no change.
        for (k = OP_SPARE_LO; k <= OP_SPARE_HI; k++)
            send_op(t_op'(k), pick_word());

        // Fill to the brim, overflow at both ends, then list a full ring.
        for (k = 0; k < DEPTH - 2; k++)
            send_op(random_push(), pick_word());
        send_op(OP_PUSH_FRONT, pick_word());
        send_op(OP_PUSH_REAR, pick_word());
        send_op(OP_DUMP, pick_word());

        random_end = words_sent + RANDOM_WORDS;
        hold_at    = words_sent + RANDOM_WORDS / 2;

        // Random part: mostly runs of pushes and pops that walk the ring between
        // empty and full, with dumps, mixed runs and spare codes as noise.
        while (words_sent < random_end) begin
            if (!hold_done && words_sent >= hold_at) begin
                // Starve the result side while words keep coming so the block
                // backs up and stalls its input; then pause until all is out.
                hold_done      = 1'b1;
                tx_idle        = 1'b0;
                rx_hold_cycles = HOLD_CYCLES;
                for (k = 0; k < DEPTH + 8; k++)
                    send_op(random_push(), pick_word());
                send_op(OP_DUMP, pick_word());
                wait_for_drain();
            end
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            run_len = $urandom_range(1, DEPTH + 3);
            case ($urandom_range(0, 9))
                0, 1, 2: begin
                    for (k = 0; k < run_len; k++)
                        send_op(random_push(), pick_word());
                end
                3, 4, 5: begin
                    for (k = 0; k < run_len; k++)
                        send_op($urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR,
                                pick_word());
                end
                6: send_op(OP_DUMP, pick_word());
                7: begin
                    for (k = 0; k < run_len; k++)
                        send_op(t_op'($urandom_range(OP_PUSH_FRONT, OP_DUMP)), pick_word());
                end
                8: send_op(t_op'($urandom_range(OP_SPARE_LO, OP_SPARE_HI)), pick_word());
                default: begin
                    // build up, list, and let everything settle before going on
                    for (k = 0; k < run_len; k++)
                        send_op(random_push(), pick_word());
                    send_op(OP_DUMP, pick_word());
                    wait_for_drain();
                end
            endcase
        end

        // Settle: wait for the last words, then watch for strays.
        wait_for_drain();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0 && pending_words == 0)
            $display("tb_circular_deque_engine: clean");
        else
            $display("tb_circular_deque_engine: errors");
        $finish;
    end

endmodule
